>>> rtl/erf_pkg.sv
// ----------------------------------------------------------------------------
// erf_pkg: shared definitions for the encoder frame receiver
// Frame layout constants, register indexes, the frame record passed from
// the front part to the back part, and the CRC-16/Modbus byte update.
// ----------------------------------------------------------------------------
package erf_pkg;

  localparam int unsigned CRC_SPAN  = 6;
  localparam int unsigned FRAME_LEN = 2 * CRC_SPAN + 3;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned COUNT_SCALE = 10000;
  localparam int unsigned COUNT_W     = 30;
  localparam int unsigned DELTA_W     = 31;

  localparam logic [7:0] HEADER_RESET       = 8'h01;
  localparam logic       INVERT_LEFT_RESET  = 1'b1;
  localparam logic       INVERT_RIGHT_RESET = 1'b0;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_HEADER       = 2'd0;
  localparam logic [1:0] REG_INVERT_LEFT  = 2'd1;
  localparam logic [1:0] REG_INVERT_RIGHT = 2'd2;

  // Result of one completed frame: check outcome and the words now kept
  typedef struct packed {
    logic        ok;
    logic [31:0] right_word;
    logic [31:0] left_word;
  } erf_rec_t;

  // Wheel settings seen by the back part
  typedef struct packed {
    logic invert_left;
    logic invert_right;
  } erf_cfg_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/encoder_frame_receiver.sv
// ----------------------------------------------------------------------------
// encoder_frame_receiver: encoder reply frame checker
// Hunts a received byte stream for the header, checks both CRC-16/Modbus
// fields of a 15-byte frame and turns the kept encoder words into counts
// and per-frame deltas.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   in_       input      rx_byte, one received byte per beat
//   out_      output     frame_ok, left/right count, left/right delta
//   cfg (APB) input      header_byte @0x0, invert_left @0x4, invert_right @0x8
//
// One byte beat is taken every cycle while in_stall is low; the byte stream
// never waits on the CRC update, which is one byte-wide step per beat in the
// front part. A frame's record enters the queue on the edge that takes its
// last byte beat, then passes the product stage (16x15 multiply), count
// stage and output register before its result beat shows on out_.
// in_stall rises only while the record queue is full, i.e. when out_ has
// been stalled across several whole frames.
// Reset is synchronous on rst_n; it clears control state and returns the
// settings to their defaults.
//
module encoder_frame_receiver #(
  parameter int unsigned QUEUE_DEPTH = erf_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // byte channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_frame_ok,
  output logic signed [erf_pkg::COUNT_W-1:0]  out_left_count,
  output logic signed [erf_pkg::COUNT_W-1:0]  out_right_count,
  output logic signed [erf_pkg::DELTA_W-1:0]  out_left_delta,
  output logic signed [erf_pkg::DELTA_W-1:0]  out_right_delta,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [erf_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [erf_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [erf_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import erf_pkg::*;

  logic [7:0] header_r;
  logic       invert_left_r;
  logic       invert_right_r;
  logic [1:0] reg_idx;
  logic       cfg_write;

  erf_rec_t   front_rec, queue_rec;
  erf_cfg_t   back_cfg;
  logic       byte_take, rec_push, q_full, q_not_empty, rec_pop;

  // Register file: word-aligned, writes outside the list drop silently
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r       <= HEADER_RESET;
      invert_left_r  <= INVERT_LEFT_RESET;
      invert_right_r <= INVERT_RIGHT_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_HEADER:       header_r       <= pwdata[7:0];
        REG_INVERT_LEFT:  invert_left_r  <= pwdata[0];
        REG_INVERT_RIGHT: invert_right_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEADER:       prdata = {(APB_DATA_W - 8)'(0), header_r};
      REG_INVERT_LEFT:  prdata = {(APB_DATA_W - 1)'(0), invert_left_r};
      REG_INVERT_RIGHT: prdata = {(APB_DATA_W - 1)'(0), invert_right_r};
      default:          prdata = '0;
    endcase
  end

  // Hold byte beats only while the record queue has no room
  assign in_stall  = q_full;
  assign byte_take = in_valid && !in_stall;

  assign back_cfg.invert_left  = invert_left_r;
  assign back_cfg.invert_right = invert_right_r;

  erf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .header_byte (header_r),
    .byte_take   (byte_take),
    .rx_byte     (in_rx_byte),
    .rec_push    (rec_push),
    .rec         (front_rec)
  );

  erf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (front_rec),
    .full      (q_full),
    .pop       (rec_pop),
    .not_empty (q_not_empty),
    .pop_data  (queue_rec)
  );

  erf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (back_cfg),
    .rec_valid       (q_not_empty),
    .rec             (queue_rec),
    .rec_pop         (rec_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_ok    (out_frame_ok),
    .out_left_count  (out_left_count),
    .out_right_count (out_right_count),
    .out_left_delta  (out_left_delta),
    .out_right_delta (out_right_delta)
  );

endmodule

>>> rtl/erf_front.sv
// ----------------------------------------------------------------------------
// erf_front: byte hunter, frame capture and CRC checks
// Hunts for the header, captures the frame, runs both CRCs and emits one
// record per completed frame.
// ----------------------------------------------------------------------------
module erf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        header_byte,
  input  logic              byte_take,
  input  logic [7:0]        rx_byte,
  output logic              rec_push,
  output erf_pkg::erf_rec_t rec
);
  import erf_pkg::*;

  localparam logic [POS_W-1:0] CRC1_LAST  = POS_W'(CRC_SPAN - 2);
  localparam logic [POS_W-1:0] CRC2_FIRST = POS_W'(CRC_SPAN + 1);
  localparam logic [POS_W-1:0] CRC2_LAST  = POS_W'(2 * CRC_SPAN);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_LEN - 1);
  localparam int unsigned      LEFT_FIRST = CRC_SPAN + 3;

  logic             collecting_r, collecting_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc1_r, crc1_nxt;
  logic [15:0]      crc2_r, crc2_nxt;
  logic [31:0]      right_word_r, left_word_r;
  logic [7:0]       cap_r [FRAME_LEN];
  logic             ok;
  logic [15:0]      crc_step;

  assign crc_step = crc_feed(((!collecting_r) || (pos_r <= CRC1_LAST)) ?
                             ((!collecting_r) ? CRC_INIT : crc1_r) : crc2_r, rx_byte);

  assign ok = (cap_r[CRC_SPAN - 1] == crc1_r[7:0]) &&
              (cap_r[CRC_SPAN] == crc1_r[15:8]) &&
              (cap_r[2 * CRC_SPAN + 1] == crc2_r[7:0]) &&
              (rx_byte == crc2_r[15:8]);

  always_comb begin
    collecting_nxt = collecting_r;
    pos_nxt        = pos_r;
    crc1_nxt       = crc1_r;
    crc2_nxt       = crc2_r;
    rec_push       = 1'b0;
    if (byte_take) begin
      if (!collecting_r) begin
        if (rx_byte == header_byte) begin
          collecting_nxt = 1'b1;
          pos_nxt        = '0;
          crc1_nxt       = crc_step;
          crc2_nxt       = CRC_INIT;
        end
      end else begin
        if (pos_r <= CRC1_LAST) begin
          crc1_nxt = crc_step;
        end else if ((pos_r >= CRC2_FIRST) && (pos_r <= CRC2_LAST)) begin
          crc2_nxt = crc_step;
        end
        if (pos_r != LAST_POS) begin
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          collecting_nxt = 1'b0;
          pos_nxt        = '0;
          rec_push       = 1'b1;
        end
      end
    end
  end

  always_comb begin
    rec.ok         = ok;
    rec.right_word = right_word_r;
    rec.left_word  = left_word_r;
    if (ok) begin
      rec.right_word = {cap_r[1], cap_r[2], cap_r[3], cap_r[4]};
      rec.left_word  = {cap_r[LEFT_FIRST], cap_r[LEFT_FIRST + 1],
                        cap_r[LEFT_FIRST + 2], cap_r[LEFT_FIRST + 3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      pos_r        <= '0;
      crc1_r       <= CRC_INIT;
      crc2_r       <= CRC_INIT;
      right_word_r <= '0;
      left_word_r  <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      pos_r        <= pos_nxt;
      crc1_r       <= crc1_nxt;
      crc2_r       <= crc2_nxt;
      if (rec_push) begin
        right_word_r <= rec.right_word;
        left_word_r  <= rec.left_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && collecting_r) begin
      cap_r[pos_r] <= rx_byte;
    end
  end

endmodule

>>> rtl/erf_queue.sv
// ----------------------------------------------------------------------------
// erf_queue: short record queue
// Decouples the front part from the back part.
// ----------------------------------------------------------------------------
module erf_queue #(
  parameter int unsigned DEPTH = erf_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  erf_pkg::erf_rec_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output erf_pkg::erf_rec_t pop_data
);
  import erf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  erf_rec_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/erf_back.sv
// ----------------------------------------------------------------------------
// erf_back: count and delta pipeline
// Scales the encoder words into counts, forms the deltas against the
// previous frame and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
module erf_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  erf_pkg::erf_cfg_t                   cfg,
  input  logic                                rec_valid,
  input  erf_pkg::erf_rec_t                   rec,
  output logic                                rec_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_frame_ok,
  output logic signed [erf_pkg::COUNT_W-1:0]  out_left_count,
  output logic signed [erf_pkg::COUNT_W-1:0]  out_right_count,
  output logic signed [erf_pkg::DELTA_W-1:0]  out_left_delta,
  output logic signed [erf_pkg::DELTA_W-1:0]  out_right_delta
);
  import erf_pkg::*;

  localparam logic signed [14:0] SCALE = 15'(COUNT_SCALE);

  // stage 1: products
  logic                      s1_v_r;
  logic                      s1_ok_r;
  logic signed [COUNT_W-1:0] s1_lprod_r, s1_rprod_r;
  logic [15:0]               s1_llo_r, s1_rlo_r;
  // stage 2: counts
  logic                      s2_v_r;
  logic                      s2_ok_r;
  logic signed [COUNT_W-1:0] s2_lcount_r, s2_rcount_r;
  // output stage
  logic                      out_valid_r;
  logic                      seen_r;
  logic signed [COUNT_W-1:0] prev_left_r, prev_right_r;

  logic signed [15:0]        lhi, rhi;
  logic signed [COUNT_W-1:0] lprod_full, rprod_full;
  logic signed [DELTA_W-1:0] ldelta_nxt, rdelta_nxt;
  logic                      out_free, s2_free, s1_free, s2_adv, s1_adv;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_adv   = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_adv   = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign rec_pop  = rec_valid && s1_free;

  assign lhi        = $signed(rec.left_word[31:16]);
  assign rhi        = $signed(rec.right_word[31:16]);
  assign lprod_full = lhi * SCALE;
  assign rprod_full = rhi * SCALE;

  always_comb begin
    ldelta_nxt = '0;
    rdelta_nxt = '0;
    if (seen_r) begin
      if (cfg.invert_left) begin
        ldelta_nxt = {prev_left_r[COUNT_W-1], prev_left_r} -
                     {s2_lcount_r[COUNT_W-1], s2_lcount_r};
      end else begin
        ldelta_nxt = {s2_lcount_r[COUNT_W-1], s2_lcount_r} -
                     {prev_left_r[COUNT_W-1], prev_left_r};
      end
      if (cfg.invert_right) begin
        rdelta_nxt = {prev_right_r[COUNT_W-1], prev_right_r} -
                     {s2_rcount_r[COUNT_W-1], s2_rcount_r};
      end else begin
        rdelta_nxt = {s2_rcount_r[COUNT_W-1], s2_rcount_r} -
                     {prev_right_r[COUNT_W-1], prev_right_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      seen_r       <= 1'b0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
    end else begin
      if (s1_free) begin
        s1_v_r <= rec_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_valid_r <= s2_v_r;
      end
      if (s2_adv) begin
        seen_r       <= 1'b1;
        prev_left_r  <= s2_lcount_r;
        prev_right_r <= s2_rcount_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_ok_r    <= rec.ok;
      s1_lprod_r <= lprod_full;
      s1_rprod_r <= rprod_full;
      s1_llo_r   <= rec.left_word[15:0];
      s1_rlo_r   <= rec.right_word[15:0];
    end
    if (s1_adv) begin
      s2_ok_r     <= s1_ok_r;
      s2_lcount_r <= s1_lprod_r + $signed({(COUNT_W - 16)'(0), s1_llo_r});
      s2_rcount_r <= s1_rprod_r + $signed({(COUNT_W - 16)'(0), s1_rlo_r});
    end
    if (s2_adv) begin
      out_frame_ok    <= s2_ok_r;
      out_left_count  <= s2_lcount_r;
      out_right_count <= s2_rcount_r;
      out_left_delta  <= ldelta_nxt;
      out_right_delta <= rdelta_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> tb/encoder_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_frame_receiver_test: self-checking bench for the frame receiver
// Streams received bytes (valid frames, damaged frames and line noise) under
// several register settings, predicts every result beat with a local model
// of the header hunt, both CRC-16/Modbus checks and the count arithmetic,
// and checks each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module encoder_frame_receiver_test;
  import erf_pkg::*;

  // Register index that maps to nothing; a write there must be dropped
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // Encoder words that give the largest and smallest count
  localparam logic [31:0] WORD_MAX = {16'h7FFF, 16'hFFFF};
  localparam logic [31:0] WORD_MIN = {16'h8000, 16'h0000};

  // Cycles to let pass after the last result before touching a register
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;

  typedef struct {
    logic                      ok;
    logic signed [COUNT_W-1:0] left_count;
    logic signed [COUNT_W-1:0] right_count;
    logic signed [DELTA_W-1:0] left_delta;
    logic signed [DELTA_W-1:0] right_delta;
  } frame_report_t;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_rx_byte;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_frame_ok;
  logic signed [COUNT_W-1:0] out_left_count;
  logic signed [COUNT_W-1:0] out_right_count;
  logic signed [DELTA_W-1:0] out_left_delta;
  logic signed [DELTA_W-1:0] out_right_delta;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0]     pwdata;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;

  encoder_frame_receiver dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_ok    (out_frame_ok),
    .out_left_count  (out_left_count),
    .out_right_count (out_right_count),
    .out_left_delta  (out_left_delta),
    .out_right_delta (out_right_delta),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  // Idle knobs: longest sender gap and longest receiver stall per beat
  int unsigned tx_gap_max   = 3;
  int unsigned rx_stall_max = 3;
  // Receiver stall countdown, and a one-shot request for a long hold-off
  int unsigned rx_wait_left = 0;
  int unsigned rx_hold_req  = 0;

  int unsigned fails           = 0;
  int unsigned bytes_sent      = 0;
  int unsigned reports_seen    = 0;
  int unsigned reports_ok      = 0;
  int unsigned in_stall_cycles = 0;

  frame_report_t pending_reports[$];

  // Frame under construction: header at 0, frame bytes 0..14 at 1..15
  logic [7:0] frame_buf [FRAME_LEN+1];

  // Predictor copy of the settings
  logic [7:0] header_sel;
  logic       inv_left_sel;
  logic       inv_right_sel;

  // Predictor copy of the receive state
  logic        in_frame;
  int unsigned frame_pos;
  logic [15:0] crc_head;
  logic [15:0] crc_tail;
  logic [7:0]  capture [FRAME_LEN];
  logic [31:0] kept_left;
  logic [31:0] kept_right;
  longint      prev_left;
  longint      prev_right;
  logic        had_frame;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // One byte of CRC-16/Modbus, reflected, LSB first
  function automatic logic [15:0] modbus_crc_byte(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Signed high half scaled by 10000, plus the unsigned low half
  function automatic longint wheel_count(logic [31:0] w);
    return longint'($signed(w[31:16])) * longint'(COUNT_SCALE) + longint'(w[15:0]);
  endfunction

  // Advance the receive state by one accepted byte; queue a report when a
  // frame completes
  task automatic track_rx_byte(input logic [7:0] b);
    logic          ok;
    longint        lc;
    longint        rc;
    longint        ld;
    longint        rd;
    frame_report_t rep;
    if (!in_frame) begin
      // Hunt: drop everything but the header, which seeds the first CRC
      if (b == header_sel) begin
        in_frame  = 1'b1;
        frame_pos = 0;
        crc_head  = modbus_crc_byte(CRC_INIT, b);
        crc_tail  = CRC_INIT;
      end
      return;
    end
    capture[frame_pos] = b;
    if (frame_pos <= CRC_SPAN - 2) begin
      crc_head = modbus_crc_byte(crc_head, b);
    end else if (frame_pos >= CRC_SPAN + 1 && frame_pos <= 2 * CRC_SPAN) begin
      crc_tail = modbus_crc_byte(crc_tail, b);
    end
    if (frame_pos < FRAME_LEN - 1) begin
      frame_pos++;
      return;
    end
    in_frame  = 1'b0;
    frame_pos = 0;

    ok = capture[CRC_SPAN-1] == crc_head[7:0] && capture[CRC_SPAN] == crc_head[15:8] &&
         capture[2*CRC_SPAN+1] == crc_tail[7:0] && capture[2*CRC_SPAN+2] == crc_tail[15:8];
    if (ok) begin
      kept_right = {capture[1], capture[2], capture[3], capture[4]};
      kept_left  = {capture[CRC_SPAN+3], capture[CRC_SPAN+4],
                    capture[CRC_SPAN+5], capture[CRC_SPAN+6]};
    end
    lc = wheel_count(kept_left);
    rc = wheel_count(kept_right);
    // First frame, pass or fail, references itself: zero deltas
    if (!had_frame) begin
      had_frame  = 1'b1;
      prev_left  = lc;
      prev_right = rc;
    end
    ld = lc - prev_left;
    rd = rc - prev_right;
    if (inv_left_sel) ld = -ld;
    if (inv_right_sel) rd = -rd;
    prev_left  = lc;
    prev_right = rc;

    rep.ok          = ok;
    rep.left_count  = lc[COUNT_W-1:0];
    rep.right_count = rc[COUNT_W-1:0];
    rep.left_delta  = ld[DELTA_W-1:0];
    rep.right_delta = rd[DELTA_W-1:0];
    pending_reports.insert(pending_reports.size(), rep);
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one byte beat after a random gap; hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    track_rx_byte(b);
  endtask

  // Fill frame_buf with a well-formed frame, then damage one byte if asked
  task automatic build_frame(input logic [31:0] right_w, input logic [31:0] left_w,
                             input logic [7:0] filler, input int corrupt_at);
    logic [15:0] c;
    frame_buf[0] = header_sel;
    frame_buf[1] = filler;
    {frame_buf[2], frame_buf[3], frame_buf[4], frame_buf[5]} = right_w;
    c = CRC_INIT;
    for (int i = 0; i <= CRC_SPAN - 1; i++) c = modbus_crc_byte(c, frame_buf[i]);
    frame_buf[CRC_SPAN]   = c[7:0];
    frame_buf[CRC_SPAN+1] = c[15:8];
    frame_buf[CRC_SPAN+2] = ~filler;
    frame_buf[CRC_SPAN+3] = filler ^ 8'h3C;
    {frame_buf[CRC_SPAN+4], frame_buf[CRC_SPAN+5],
     frame_buf[CRC_SPAN+6], frame_buf[CRC_SPAN+7]} = left_w;
    c = CRC_INIT;
    for (int i = CRC_SPAN + 2; i <= 2 * CRC_SPAN + 1; i++) c = modbus_crc_byte(c, frame_buf[i]);
    frame_buf[2*CRC_SPAN+2] = c[7:0];
    frame_buf[2*CRC_SPAN+3] = c[15:8];
    if (corrupt_at >= 0) frame_buf[corrupt_at] ^= 8'($urandom_range(1, 255));
  endtask

  task automatic send_frame(input logic [31:0] right_w, input logic [31:0] left_w,
                            input logic [7:0] filler, input int corrupt_at);
    build_frame(right_w, left_w, filler, corrupt_at);
    for (int i = 0; i <= FRAME_LEN; i++) send_byte(frame_buf[i]);
  endtask

  // APB write: setup, then access; commit at the edge where pready is seen
  task automatic write_setting(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_HEADER:       header_sel    = val[7:0];
      REG_INVERT_LEFT:  inv_left_sel  = val[0];
      REG_INVERT_RIGHT: inv_right_sel = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering, wait out every queued report, then let the pipe settle
  task automatic wait_all_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_reports.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly random words, with the count extremes and values near zero mixed in
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return {($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // --------------------------------------------------------------------------
  // Count down the stall for the next beat; a hold-off request overrides it
  always @(negedge clk) begin
    if (rx_hold_req != 0) begin
      rx_wait_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_wait_left != 0) begin
      out_stall <= 1'b1;
      rx_wait_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each taken result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    frame_report_t want;
    if (rst_n) begin
      if (in_valid && in_stall) in_stall_cycles++;
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (out_frame_ok) reports_ok++;
        if (pending_reports.size() == 0) begin
          $error("result beat with no prediction waiting");
          fails++;
        end else begin
          want = pending_reports.pop_front();
          if (out_frame_ok !== want.ok) begin
            $error("frame_ok: expected %0d, got %0d", want.ok, out_frame_ok);
            fails++;
          end
          if (out_left_count !== want.left_count) begin
            $error("left_count: expected %0d, got %0d", want.left_count, out_left_count);
            fails++;
          end
          if (out_right_count !== want.right_count) begin
            $error("right_count: expected %0d, got %0d", want.right_count, out_right_count);
            fails++;
          end
          if (out_left_delta !== want.left_delta) begin
            $error("left_delta: expected %0d, got %0d", want.left_delta, out_left_delta);
            fails++;
          end
          if (out_right_delta !== want.right_delta) begin
            $error("right_delta: expected %0d, got %0d", want.right_delta, out_right_delta);
            fails++;
          end
        end
        // Draw the stall that precedes the next beat
        rx_wait_left = $urandom_range(0, rx_stall_max);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Drop line noise, then fail the very first frame: zero counts and deltas
  task automatic test_first_frame_fails();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_frame(WORD_MAX, WORD_MAX, 8'h55, CRC_SPAN);
  endtask

  // Swing both wheels between the count extremes to hit both delta extremes
  task automatic test_count_extremes();
    send_frame(WORD_MAX, WORD_MIN, 8'h00, -1);
    send_frame(WORD_MIN, WORD_MAX, 8'hFF, -1);
    send_frame(WORD_MAX, WORD_MIN, 8'hAA, -1);
  endtask

  // Damage the second CRC, then a data byte: words stay, deltas go to zero
  task automatic test_failed_checks();
    send_frame(32'h0001_0002, 32'hFFFF_1234, 8'h11, 2 * CRC_SPAN + 2);
    send_frame(32'h0001_0002, 32'hFFFF_1234, 8'h22, 3);
  endtask

  // Put the header value inside the frame: it must be taken as data
  task automatic test_header_as_data();
    send_frame({header_sel, header_sel, header_sel, header_sel}, 32'h0000_0000,
               header_sel, -1);
  endtask

  // Change header and right invert after the header of a frame has arrived
  task automatic test_setting_mid_frame();
    build_frame(32'h1234_5678, 32'h8765_4321, 8'h01, -1);
    for (int i = 0; i <= CRC_SPAN + 1; i++) send_byte(frame_buf[i]);
    wait_all_reports();
    write_setting(REG_HEADER, 32'h0000_00A5);
    write_setting(REG_INVERT_RIGHT, 32'h0000_0001);
    for (int i = CRC_SPAN + 2; i <= FRAME_LEN; i++) send_byte(frame_buf[i]);
    send_frame(32'h0000_0100, 32'h0000_0200, 8'h5A, -1);
  endtask

  // A write past the last register must leave the settings alone
  task automatic test_unmapped_register();
    wait_all_reports();
    write_setting(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_frame(32'h0002_0003, 32'h0004_0005, 8'hC3, -1);
  endtask

  // Hold the result side off long enough that the block backs up its input
  task automatic test_receiver_hold();
    wait_all_reports();
    tx_gap_max  = 0;
    rx_hold_req = 400;
    repeat (24) send_frame(pick_word(), pick_word(), 8'($urandom), -1);
    tx_gap_max = 3;
  endtask

  // Pause the sender until every report is in, then resume
  task automatic test_sender_pause();
    repeat (4) send_frame(pick_word(), pick_word(), 8'($urandom), -1);
    wait_all_reports();
    repeat (4) send_frame(pick_word(), pick_word(), 8'($urandom), -1);
  endtask

  // Mostly good frames with random content, some damaged frames, some noise
  task automatic random_traffic(input int unsigned byte_budget);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(pick_word(), pick_word(), 8'($urandom), -1);
      end else if (pick < 85) begin
        send_frame(pick_word(), pick_word(), 8'($urandom), $urandom_range(0, FRAME_LEN));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  // Walk through several register settings and idle patterns
  task automatic test_random_settings();
    logic [7:0] hdr;
    logic       il;
    logic       ir;
    for (int ph = 0; ph < 6; ph++) begin
      wait_all_reports();
      case (ph)
        0: begin hdr = 8'h00; il = 1'b0; ir = 1'b0; tx_gap_max = 0; rx_stall_max = 0; end
        1: begin hdr = 8'hFF; il = 1'b1; ir = 1'b1; tx_gap_max = 10; rx_stall_max = 10; end
        2: begin hdr = 8'($urandom); il = 1'b0; ir = 1'b1; tx_gap_max = 3; rx_stall_max = 8; end
        3: begin hdr = 8'($urandom); il = 1'b1; ir = 1'b0; tx_gap_max = 10; rx_stall_max = 0; end
        4: begin hdr = HEADER_RESET; il = 1'b1; ir = 1'b0; tx_gap_max = 5; rx_stall_max = 5; end
        default: begin
          hdr = 8'($urandom);
          il  = 1'($urandom);
          ir  = 1'($urandom);
          tx_gap_max   = 10;
          rx_stall_max = 2;
        end
      endcase
      write_setting(REG_HEADER, {24'h0, hdr});
      write_setting(REG_INVERT_LEFT, {31'h0, il});
      write_setting(REG_INVERT_RIGHT, {31'h0, ir});
      random_traffic(190);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value and hold reset
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    // Predictor starts from the reset settings and an idle receiver
    header_sel    = HEADER_RESET;
    inv_left_sel  = INVERT_LEFT_RESET;
    inv_right_sel = INVERT_RIGHT_RESET;
    in_frame      = 1'b0;
    frame_pos     = 0;
    crc_head      = CRC_INIT;
    crc_tail      = CRC_INIT;
    kept_left     = '0;
    kept_right    = '0;
    prev_left     = 0;
    prev_right    = 0;
    had_frame     = 1'b0;
    for (int i = 0; i < FRAME_LEN; i++) capture[i] = 8'h00;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_frame_fails();
    test_count_extremes();
    test_failed_checks();
    test_header_as_data();
    test_setting_mid_frame();
    test_unmapped_register();
    test_receiver_hold();
    test_sender_pause();
    test_random_settings();

    // Drain; anything still queued is a missing result
    wait_all_reports();
    if (pending_reports.size() != 0) begin
      $error("%0d predicted results never arrived", pending_reports.size());
      fails++;
    end

    $display("covered %0d bytes, %0d frame results (%0d passed CRC), six register settings",
             bytes_sent, reports_seen, reports_ok);
    $display("input held off for %0d cycles while results backed up", in_stall_cycles);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/erf_pkg.sv
rtl/erf_front.sv
rtl/erf_queue.sv
rtl/erf_back.sv
rtl/encoder_frame_receiver.sv
tb/encoder_frame_receiver_test.sv
